### rtl/epdm_pkg.sv
// shared widths, codes and inter-module structs for the e-paper erase/ink mask block
// no dependencies
package epdm_pkg;

  localparam int ROW_W      = 10;
  localparam int BCOL_W     = 9;
  localparam int BYTE_W     = 8;
  localparam int COL_W      = 10;
  localparam int NIB_W      = 4;
  localparam int SLOT_W     = 3;
  localparam int RECT_W     = 10;
  localparam int CNT_OUT_W  = 19;
  localparam int ADDR_W     = 16;
  localparam int BOFS_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [COL_W-1:0] COL_START_RST     = 10'd0;
  localparam logic [COL_W-1:0] COL_WIDTH_RST     = 10'd960;
  localparam logic [NIB_W-1:0] INK_MAX_RST       = 4'd12;
  localparam logic [NIB_W-1:0] PERSIST_COUNT_RST = 4'd0;

  localparam logic [NIB_W-1:0] NIB_WHITE = 4'h0;
  localparam logic [NIB_W-1:0] NIB_HOLD  = 4'hF;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_RECT  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COL_START     = 2'd0,
    CFG_COL_WIDTH     = 2'd1,
    CFG_INK_MAX       = 2'd2,
    CFG_PERSIST_COUNT = 2'd3
  } cfg_idx_t;

  // rect table write toward one lane
  typedef struct packed {
    logic              wr;
    logic [RECT_W-1:0] left;
    logic [RECT_W-1:0] top;
    logic [RECT_W-1:0] width;
    logic [RECT_W-1:0] height;
  } rect_wr_t;

  // lookup toward every lane
  typedef struct packed {
    logic             adv;
    logic             active;
    logic [COL_W-1:0] px0;
    logic [ROW_W-1:0] row;
  } lane_req_t;

  // first stage contents for one pixel pair
  typedef struct packed {
    logic              band_first;
    logic              band_last;
    logic [ROW_W-1:0]  row;
    logic [BCOL_W-1:0] byte_col;
    logic [1:0]        in_span;
    logic [1:0]        cur_ink;
    logic [1:0]        prev_ink;
  } pix_stage_t;

endpackage

### rtl/epdm_in_if.sv
// input channel: pixel pair or persistent rect load, valid/ready
// depends on epdm_pkg
interface epdm_in_if;
  import epdm_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic              band_first;
  logic              band_last;
  logic [ROW_W-1:0]  pixel_row;
  logic [BCOL_W-1:0] byte_col;
  logic [BYTE_W-1:0] cur_byte;
  logic [BYTE_W-1:0] prev_byte;
  logic [SLOT_W-1:0] rect_slot;
  logic [RECT_W-1:0] rect_left;
  logic [RECT_W-1:0] rect_top;
  logic [RECT_W-1:0] rect_width;
  logic [RECT_W-1:0] rect_height;

  modport source (
    output valid, req_type, band_first, band_last, pixel_row, byte_col, cur_byte,
           prev_byte, rect_slot, rect_left, rect_top, rect_width, rect_height,
    input  ready
  );
  modport sink (
    input  valid, req_type, band_first, band_last, pixel_row, byte_col, cur_byte,
           prev_byte, rect_slot, rect_left, rect_top, rect_width, rect_height,
    output ready
  );
endinterface

### rtl/epdm_out_if.sv
// result channel: erase mask, ink bits, ink byte address and offset, running band counts, valid/ready
// depends on epdm_pkg
interface epdm_out_if;
  import epdm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [BYTE_W-1:0]    erase_mask;
  logic [1:0]           ink_bits;
  logic [ADDR_W-1:0]    ink_byte_addr;
  logic [BOFS_W-1:0]    ink_bit_offset;
  logic                 any_erase;
  logic [CNT_OUT_W-1:0] erase_count;
  logic [CNT_OUT_W-1:0] ink_count;
  logic                 band_end;

  modport source (
    output valid, erase_mask, ink_bits, ink_byte_addr, ink_bit_offset, any_erase,
           erase_count, ink_count, band_end,
    input  ready
  );
  modport sink (
    input  valid, erase_mask, ink_bits, ink_byte_addr, ink_bit_offset, any_erase,
           erase_count, ink_count, band_end,
    output ready
  );
endinterface

### rtl/epdm_rect_lane.sv
// one persistent rect slot: holds the rect and tests both pixels of a pair against it
// depends on epdm_pkg
module epdm_rect_lane (
  input  logic                clk,
  input  epdm_pkg::rect_wr_t  wr,
  input  epdm_pkg::lane_req_t req,
  output logic [1:0]          hit_r
);
  import epdm_pkg::*;

  logic [RECT_W-1:0] left_r, top_r, width_r, height_r;
  logic [RECT_W:0]   right_end, bot_end;
  logic [COL_W-1:0]  px [2];
  logic              row_ok;
  logic [1:0]        hit_nxt;

  // rect contents are undefined until loaded
  always_ff @(posedge clk) begin
    if (wr.wr) begin
      left_r   <= wr.left;
      top_r    <= wr.top;
      width_r  <= wr.width;
      height_r <= wr.height;
    end
  end

  always_comb begin
    right_end = {1'b0, left_r} + {1'b0, width_r};
    bot_end   = {1'b0, top_r} + {1'b0, height_r};
    px[0]     = req.px0;
    px[1]     = {req.px0[COL_W-1:1], 1'b1};
    row_ok    = (req.row >= top_r) && ({1'b0, req.row} < bot_end);
    for (int k = 0; k < 2; k++) begin
      hit_nxt[k] = req.active && row_ok && (px[k] >= left_r) &&
                   ({1'b0, px[k]} < right_end);
    end
  end

  always_ff @(posedge clk) begin
    if (req.adv) begin
      hit_r <= hit_nxt;
    end
  end

endmodule

### rtl/epdm_merge.sv
// merge of lane hits, per-pixel erase/ink decision, band counters and output register
// depends on epdm_pkg and epdm_out_if
module epdm_merge #(
  parameter int PANEL_WIDTH  = 960,
  parameter int PANEL_HEIGHT = 540,
  parameter int MAX_PERSIST  = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                valid_a,
  input  epdm_pkg::pix_stage_t                stage_a,
  input  logic [MAX_PERSIST-1:0][1:0]         hits,
  output logic                                a_take,
  epdm_out_if.source                          out_ch
);
  import epdm_pkg::*;

  localparam int unsigned LIM      = PANEL_WIDTH * PANEL_HEIGHT;
  localparam int          LIM_W    = $clog2(LIM + 1);
  localparam int          CNT_W    = (LIM_W > CNT_OUT_W) ? LIM_W : CNT_OUT_W;
  localparam int          ROW_BYTES = PANEL_WIDTH / 8;
  localparam logic [CNT_W-1:0] CNT_LIM = CNT_W'(LIM);

  logic [1:0]        pers, er, ik, inked;
  logic [1:0]        n_er, n_ink;
  logic [CNT_W-1:0]  er_base, ink_base, er_cnt_r, ink_cnt_r, er_cnt_nxt, ink_cnt_nxt;
  logic [CNT_W:0]    er_sum, ink_sum;
  logic              seen_r, seen_nxt, out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] mask_nxt, mask_r;
  logic [1:0]        ink_bits_r;
  logic [ADDR_W-1:0] addr_nxt, addr_r;
  logic [BOFS_W-1:0] ofs_r;
  logic              band_end_r;

  assign a_take = valid_a && (!out_valid_r || out_ch.ready);

  always_comb begin
    pers = '0;
    for (int i = 0; i < MAX_PERSIST; i++) begin
      pers = pers | hits[i];
    end
    er    = stage_a.in_span & stage_a.prev_ink & (~pers | ~stage_a.cur_ink);
    ik    = stage_a.in_span & stage_a.cur_ink & ~(pers & stage_a.prev_ink);
    inked = stage_a.in_span & stage_a.cur_ink;
    mask_nxt = {er[1] ? NIB_WHITE : NIB_HOLD, er[0] ? NIB_WHITE : NIB_HOLD};
    n_er  = {1'b0, er[0]} + {1'b0, er[1]};
    n_ink = {1'b0, inked[0]} + {1'b0, inked[1]};

    // band start clears before this pair is counted
    er_base  = stage_a.band_first ? '0 : er_cnt_r;
    ink_base = stage_a.band_first ? '0 : ink_cnt_r;
    er_sum   = {1'b0, er_base} + (CNT_W + 1)'(n_er);
    ink_sum  = {1'b0, ink_base} + (CNT_W + 1)'(n_ink);
    er_cnt_nxt  = (er_sum > {1'b0, CNT_LIM}) ? CNT_LIM : er_sum[CNT_W-1:0];
    ink_cnt_nxt = (ink_sum > {1'b0, CNT_LIM}) ? CNT_LIM : ink_sum[CNT_W-1:0];
    seen_nxt    = (stage_a.band_first ? 1'b0 : seen_r) || (er != 2'b00);

    // ink plane keeps adjacent bytes swapped
    addr_nxt = ADDR_W'(32'(stage_a.row) * ROW_BYTES) +
               ADDR_W'(stage_a.byte_col[BCOL_W-1:2] ^ 7'd1);

    if (a_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      er_cnt_r    <= '0;
      ink_cnt_r   <= '0;
      seen_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (a_take) begin
        er_cnt_r  <= er_cnt_nxt;
        ink_cnt_r <= ink_cnt_nxt;
        seen_r    <= seen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_take) begin
      mask_r     <= mask_nxt;
      ink_bits_r <= ik;
      addr_r     <= addr_nxt;
      ofs_r      <= {stage_a.byte_col[1:0], 1'b0};
      band_end_r <= stage_a.band_last;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.erase_mask     = mask_r;
  assign out_ch.ink_bits       = ink_bits_r;
  assign out_ch.ink_byte_addr  = addr_r;
  assign out_ch.ink_bit_offset = ofs_r;
  assign out_ch.any_erase      = seen_r;
  assign out_ch.erase_count    = er_cnt_r[CNT_OUT_W-1:0];
  assign out_ch.ink_count      = ink_cnt_r[CNT_OUT_W-1:0];
  assign out_ch.band_end       = band_end_r;

endmodule

### rtl/epaper_diff_erase_ink_mask.sv
// top level of the e-paper differential erase / ink mask generator
// depends on epdm_pkg, epdm_in_if, epdm_out_if, epdm_rect_lane and epdm_merge

// One pixel pair (a framebuffer byte of two 4-bit pixels plus the byte shown
// before) is taken per clock while the output is not stalled and gives one
// result: an erase nibble per pixel (0x0 drive white, 0xF leave), one ink bit
// per pixel, the swapped ink byte address and bit offset, and running band
// counts. Throughput is one transfer per cycle unless the output stalls. The
// two register stages are stage a, which holds the span and ink tests beside
// the registered rect compare in the lanes, and the output register, which is
// fed by the merge/counter logic and offers the result. A rect load transfer
// writes one persistent rect slot and gives no result. Each of the MAX_PERSIST
// lanes holds one rect and compares both pixels against it in parallel. The
// rect slots hold no reset value and must be loaded before persist_count
// enables them. Configuration writes take effect at once and are meant to
// happen only while idle.
module epaper_diff_erase_ink_mask #(
  parameter int PANEL_WIDTH  = 960,
  parameter int PANEL_HEIGHT = 540,
  parameter int MAX_PERSIST  = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  epdm_in_if.sink                         in_ch,
  epdm_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [epdm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [epdm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import epdm_pkg::*;

  // configuration registers
  logic [COL_W-1:0] col_start_r, col_width_r;
  logic [NIB_W-1:0] ink_max_r, persist_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_start_r     <= COL_START_RST;
      col_width_r     <= COL_WIDTH_RST;
      ink_max_r       <= INK_MAX_RST;
      persist_count_r <= PERSIST_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_COL_START:     col_start_r     <= cfg_wdata[COL_W-1:0];
        CFG_COL_WIDTH:     col_width_r     <= cfg_wdata[COL_W-1:0];
        CFG_INK_MAX:       ink_max_r       <= cfg_wdata[NIB_W-1:0];
        CFG_PERSIST_COUNT: persist_count_r <= cfg_wdata[NIB_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: stage a drains into the output register whenever that frees up
  logic       valid_a_r, valid_a_nxt, a_take, in_xfer, pix_load, rect_load;
  pix_stage_t stage_a_r, stage_a_nxt;

  assign in_ch.ready = !valid_a_r || a_take;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign pix_load    = in_xfer && (in_ch.req_type == REQ_PIXEL);
  assign rect_load   = in_xfer && (in_ch.req_type == REQ_RECT);

  // span and ink tests on the incoming pair
  logic [COL_W:0]   span_end;
  logic [COL_W-1:0] px [2];
  logic [NIB_W-1:0] cn [2];
  logic [NIB_W-1:0] pn [2];

  always_comb begin
    span_end = {1'b0, col_start_r} + {1'b0, col_width_r};
    px[0]    = {in_ch.byte_col, 1'b0};
    px[1]    = {in_ch.byte_col, 1'b1};
    cn[0]    = in_ch.cur_byte[NIB_W-1:0];
    cn[1]    = in_ch.cur_byte[BYTE_W-1:NIB_W];
    pn[0]    = in_ch.prev_byte[NIB_W-1:0];
    pn[1]    = in_ch.prev_byte[BYTE_W-1:NIB_W];
    stage_a_nxt.band_first = in_ch.band_first;
    stage_a_nxt.band_last  = in_ch.band_last;
    stage_a_nxt.row        = in_ch.pixel_row;
    stage_a_nxt.byte_col   = in_ch.byte_col;
    for (int k = 0; k < 2; k++) begin
      // span end may run past the panel, so compare one bit wider
      stage_a_nxt.in_span[k]  = (px[k] >= col_start_r) && ({1'b0, px[k]} < span_end);
      stage_a_nxt.cur_ink[k]  = cn[k] <= ink_max_r;
      stage_a_nxt.prev_ink[k] = pn[k] <= ink_max_r;
    end

    if (pix_load) begin
      valid_a_nxt = 1'b1;
    end else if (a_take) begin
      valid_a_nxt = 1'b0;
    end else begin
      valid_a_nxt = valid_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else begin
      valid_a_r <= valid_a_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_load) begin
      stage_a_r <= stage_a_nxt;
    end
  end

  // persistent rect lanes, one slot each; loads to slots past the lanes drop
  logic [MAX_PERSIST-1:0][1:0] hits;

  for (genvar i = 0; i < MAX_PERSIST; i++) begin : g_lane
    rect_wr_t  lane_wr;
    lane_req_t lane_req;

    always_comb begin
      lane_wr.wr      = rect_load && (32'(in_ch.rect_slot) == i);
      lane_wr.left    = in_ch.rect_left;
      lane_wr.top     = in_ch.rect_top;
      lane_wr.width   = in_ch.rect_width;
      lane_wr.height  = in_ch.rect_height;
      lane_req.adv    = pix_load;
      // slot i is in use when persist_count covers it, which also caps the count
      lane_req.active = 32'(persist_count_r) > i;
      lane_req.px0    = px[0];
      lane_req.row    = in_ch.pixel_row;
    end

    epdm_rect_lane u_lane (
      .clk   (clk),
      .wr    (lane_wr),
      .req   (lane_req),
      .hit_r (hits[i])
    );
  end

  // merge, decide, count and hold the result
  epdm_merge #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .MAX_PERSIST  (MAX_PERSIST)
  ) u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_a (valid_a_r),
    .stage_a (stage_a_r),
    .hits    (hits),
    .a_take  (a_take),
    .out_ch  (out_ch)
  );

`ifndef SYNTHESIS
  // a full first stage behind a stalled output must hold off new transfers
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_a_r && out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input ready while pipeline is full and stalled");

  // any erased pixel in a result implies the band erase flag
  a_erase_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && ((out_ch.erase_mask[3:0] == NIB_WHITE) ||
                      (out_ch.erase_mask[7:4] == NIB_WHITE))) |-> out_ch.any_erase)
    else $error("erase nibble without any_erase");

  // a rect load never leads to a result
  a_rect_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (rect_load && !valid_a_r && !out_ch.valid) |=> !valid_a_r)
    else $error("rect load entered the pixel pipeline");
`endif

endmodule

### tb/tb_epaper_diff_erase_ink_mask.sv
// testbench for epaper_diff_erase_ink_mask: directed and random pixel pair and
// rect load traffic with random stalls on both channels, checked against a local predictor
// depends on epdm_pkg, epdm_in_if, epdm_out_if and the rtl top level
module tb_epaper_diff_erase_ink_mask;
  import epdm_pkg::*;

  // panel geometry, kept equal to the values handed to the block
  localparam int PANEL_W   = 960;
  localparam int PANEL_H   = 540;
  localparam int MAX_RECTS = 8;
  localparam int unsigned PIX_TOTAL = PANEL_W * PANEL_H;

  // settling time after the last result: the path through the block, plus margin
  localparam int SETTLE_CYCLES = 4;
  // cycles with no transfer on either channel before the run is called hung
  localparam int QUIET_LIMIT   = 2000;

  // one input item as the sender sees it
  typedef struct packed {
    logic              req_type;
    logic              band_first;
    logic              band_last;
    logic [ROW_W-1:0]  row;
    logic [BCOL_W-1:0] bcol;
    logic [BYTE_W-1:0] cur;
    logic [BYTE_W-1:0] prev;
    logic [SLOT_W-1:0] slot;
    logic [RECT_W-1:0] left;
    logic [RECT_W-1:0] top;
    logic [RECT_W-1:0] width;
    logic [RECT_W-1:0] height;
  } epd_req_t;

  // one result, field for field as on the output channel
  typedef struct packed {
    logic [BYTE_W-1:0]    erase_mask;
    logic [1:0]           ink_bits;
    logic [ADDR_W-1:0]    ink_byte_addr;
    logic [BOFS_W-1:0]    ink_bit_offset;
    logic                 any_erase;
    logic [CNT_OUT_W-1:0] erase_count;
    logic [CNT_OUT_W-1:0] ink_count;
    logic                 band_end;
  } mask_result_t;

  typedef struct {
    int unsigned left;
    int unsigned top;
    int unsigned width;
    int unsigned height;
  } keep_rect_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  epdm_in_if  in_ch();
  epdm_out_if out_ch();

  epaper_diff_erase_ink_mask #(
    .PANEL_WIDTH (PANEL_W),
    .PANEL_HEIGHT(PANEL_H),
    .MAX_PERSIST (MAX_RECTS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // predictor copy of the registers, tables and band counters
  int unsigned m_col_start   = 0;
  int unsigned m_col_width   = 960;
  int unsigned m_ink_max     = 12;
  int unsigned m_persist     = 0;
  int unsigned m_erase_cnt   = 0;
  int unsigned m_ink_cnt     = 0;
  bit          m_erase_seen  = 1'b0;
  keep_rect_t  keep_rects[MAX_RECTS];

  mask_result_t pending_masks[$];
  mask_result_t want;
  int fails = 0;
  int quiet_cycles = 0;

  // knobs for random stalls on each side and a long hold-off of the receiver
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int rx_hold_req = 0;

  function automatic int unsigned sat_pixels(input int unsigned v);
    return (v > PIX_TOTAL) ? PIX_TOTAL : v;
  endfunction

  // apply one accepted transfer to the predictor: a rect load updates the
  // table, a pixel pair yields the expected masks and updated band counts
  function automatic void predict_masks(input epd_req_t it);
    mask_result_t r;
    int unsigned px0, px, span_end, n_keep, erased, inked, addr_full;
    logic [NIB_W-1:0] cn, pn;
    bit in_span, keep, cur_ink, prev_ink, er, ik;
    if (it.req_type == REQ_RECT) begin
      keep_rects[it.slot] = '{32'(it.left), 32'(it.top), 32'(it.width), 32'(it.height)};
      return;
    end
    if (it.band_first) begin
      m_erase_cnt  = 0;
      m_ink_cnt    = 0;
      m_erase_seen = 1'b0;
    end
    r = '0;
    erased = 0;
    inked = 0;
    px0 = it.bcol * 2;
    span_end = m_col_start + m_col_width;
    // counts above the table size act as a full table
    n_keep = (m_persist > MAX_RECTS) ? MAX_RECTS : m_persist;
    for (int k = 0; k < 2; k++) begin
      px = px0 + k;
      cn = it.cur[4*k +: 4];
      pn = it.prev[4*k +: 4];
      in_span = (px >= m_col_start) && (px < span_end);
      keep = 1'b0;
      for (int i = 0; i < n_keep; i++) begin
        if (px >= keep_rects[i].left && px < keep_rects[i].left + keep_rects[i].width &&
            it.row >= keep_rects[i].top && it.row < keep_rects[i].top + keep_rects[i].height)
          keep = 1'b1;
      end
      cur_ink  = (cn <= m_ink_max);
      prev_ink = (pn <= m_ink_max);
      // a kept pixel that is still ink is neither wiped nor inked again
      er = in_span && prev_ink && (!keep || !cur_ink);
      ik = in_span && cur_ink && !(keep && prev_ink);
      r.erase_mask[4*k +: 4] = er ? NIB_WHITE : NIB_HOLD;
      r.ink_bits[k] = ik;
      if (er) erased++;
      if (in_span && cur_ink) inked++;
    end
    if (erased != 0) m_erase_seen = 1'b1;
    m_erase_cnt = sat_pixels(m_erase_cnt + erased);
    m_ink_cnt   = sat_pixels(m_ink_cnt + inked);
    // ink plane bytes are stored with neighbors swapped
    addr_full = it.row * (PANEL_W / 8) + ((px0 >> 3) ^ 1);
    r.ink_byte_addr  = addr_full[ADDR_W-1:0];
    r.ink_bit_offset = px0[BOFS_W-1:0];
    r.any_erase      = m_erase_seen;
    r.erase_count    = m_erase_cnt[CNT_OUT_W-1:0];
    r.ink_count      = m_ink_cnt[CNT_OUT_W-1:0];
    r.band_end       = it.band_last;
    pending_masks.push_back(r);
  endfunction

  // every field random over its full width
  function automatic epd_req_t random_req();
    epd_req_t it;
    it.req_type   = 1'($urandom_range(0, 1));
    it.band_first = 1'($urandom_range(0, 1));
    it.band_last  = 1'($urandom_range(0, 1));
    it.row        = ROW_W'($urandom_range(0, 1023));
    it.bcol       = BCOL_W'($urandom_range(0, 511));
    it.cur        = BYTE_W'($urandom_range(0, 255));
    it.prev       = BYTE_W'($urandom_range(0, 255));
    it.slot       = SLOT_W'($urandom_range(0, 7));
    it.left       = RECT_W'($urandom_range(0, 1023));
    it.top        = RECT_W'($urandom_range(0, 1023));
    it.width      = RECT_W'($urandom_range(0, 1023));
    it.height     = RECT_W'($urandom_range(0, 1023));
    return it;
  endfunction

  function automatic epd_req_t pixel_pair(input bit first, input bit last,
                                          input int unsigned row, input int unsigned bcol,
                                          input int unsigned cur, input int unsigned prev);
    epd_req_t it;
    it = random_req();
    it.req_type   = REQ_PIXEL;
    it.band_first = first;
    it.band_last  = last;
    it.row        = row[ROW_W-1:0];
    it.bcol       = bcol[BCOL_W-1:0];
    it.cur        = cur[BYTE_W-1:0];
    it.prev       = prev[BYTE_W-1:0];
    return it;
  endfunction

  function automatic epd_req_t rect_load(input int unsigned slot, input int unsigned left,
                                         input int unsigned top, input int unsigned width,
                                         input int unsigned height);
    epd_req_t it;
    it = random_req();
    it.req_type = REQ_RECT;
    it.slot     = slot[SLOT_W-1:0];
    it.left     = left[RECT_W-1:0];
    it.top      = top[RECT_W-1:0];
    it.width    = width[RECT_W-1:0];
    it.height   = height[RECT_W-1:0];
    return it;
  endfunction

  // offer one item after a random gap, hold it until the transfer happens
  task automatic send_req(input epd_req_t it);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= it.req_type;
    in_ch.band_first  <= it.band_first;
    in_ch.band_last   <= it.band_last;
    in_ch.pixel_row   <= it.row;
    in_ch.byte_col    <= it.bcol;
    in_ch.cur_byte    <= it.cur;
    in_ch.prev_byte   <= it.prev;
    in_ch.rect_slot   <= it.slot;
    in_ch.rect_left   <= it.left;
    in_ch.rect_top    <= it.top;
    in_ch.rect_width  <= it.width;
    in_ch.rect_height <= it.height;
    do @(posedge clk); while (!in_ch.ready);
    predict_masks(it);
  endtask

  // stop offering and wait until every expected result is out, then let the
  // pipeline settle so a trailing rect load is surely done too
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_masks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  // registers change only while the block is idle
  task automatic load_config(input int unsigned cs, input int unsigned cw,
                             input int unsigned im, input int unsigned pc);
    drain_results();
    write_reg(CFG_COL_START, cs);
    write_reg(CFG_COL_WIDTH, cw);
    write_reg(CFG_INK_MAX, im);
    write_reg(CFG_PERSIST_COUNT, pc);
    cfg_we <= 1'b0;
    m_col_start = cs % 1024;
    m_col_width = cw % 1024;
    m_ink_max   = im % 16;
    m_persist   = pc % 16;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      fails++;
    end
  endtask

  // defaults after reset: full-width span, ink at 12 and below, no kept rects
  task automatic test_reset_values();
    send_req(pixel_pair(1, 0, 0, 0, 8'h00, 8'hFF));
    send_req(pixel_pair(0, 0, 539, 479, 8'hFF, 8'h00));
    // gray 12 is ink, 13 is paper
    send_req(pixel_pair(0, 0, 100, 200, 8'hCD, 8'hDC));
    // both pixels past the panel edge, address wraps at 16 bits
    send_req(pixel_pair(0, 1, 1023, 511, 8'h0C, 8'hC0));
  endtask

  // fill every slot first so no unloaded slot is ever looked up
  task automatic test_keep_rects();
    send_req(rect_load(0, 100, 10, 20, 5));
    send_req(rect_load(1, 0, 0, 0, 540));
    send_req(rect_load(2, 0, 0, 960, 0));
    send_req(rect_load(3, 1023, 1023, 1023, 1023));
    send_req(rect_load(4, 400, 200, 8, 1));
    send_req(rect_load(5, 0, 539, 960, 1));
    send_req(rect_load(6, 958, 0, 2, 540));
    send_req(rect_load(7, 900, 300, 60, 60));
    load_config(0, 960, 12, 1);
    // inside slot 0: still ink is kept, ink turned paper is wiped
    send_req(pixel_pair(1, 0, 12, 50, 8'hF0, 8'h00));
    // inside slot 0: paper turned ink is inked, ink turned paper is wiped
    send_req(pixel_pair(0, 0, 12, 50, 8'h0F, 8'hF0));
    // same pixels below the rect
    send_req(pixel_pair(0, 1, 20, 50, 8'h0F, 8'hF0));
    // count above the table size uses all eight slots
    load_config(0, 960, 12, 15);
    send_req(pixel_pair(1, 1, 539, 479, 8'h00, 8'h00));
  endtask

  task automatic test_span_edges();
    // empty span: nothing driven, nothing counted
    load_config(0, 0, 15, 0);
    send_req(pixel_pair(1, 0, 5, 10, 8'h00, 8'h00));
    // span starting at the last panel column and running past the panel
    load_config(959, 960, 12, 0);
    send_req(pixel_pair(0, 0, 7, 479, 8'h00, 8'hFF));
    send_req(pixel_pair(0, 0, 7, 480, 8'hF0, 8'h0F));
    // register extremes, ink only at gray 0, rect at the far corner
    load_config(1000, 1023, 0, 15);
    send_req(pixel_pair(0, 1, 1023, 511, 8'h00, 8'h00));
    send_req(pixel_pair(1, 0, 1023, 500, 8'h10, 8'h01));
  endtask

  // receiver holds off long while the sender keeps offering, so the block fills
  task automatic test_back_pressure();
    load_config(0, 960, 12, 8);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    rx_hold_req = 300;
    for (int j = 0; j < 40; j++)
      send_req(pixel_pair(j == 0, j == 39, 300, 400 + j,
                          $urandom_range(0, 255), $urandom_range(0, 255)));
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // sender stops until the block has handed out every result
  task automatic test_drain_pause();
    for (int j = 0; j < 30; j++) begin
      if (j == 15) drain_results();
      send_req(pixel_pair(j == 0, j == 29, 210, 100 + j,
                          $urandom_range(0, 255), $urandom_range(0, 255)));
    end
  endtask

  // mostly raster-ordered bands with random content, plus rect loads and noise
  task automatic test_random_bands();
    int unsigned cs, cw, row, bcol, len, sent;
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 4))
        0, 1:    cs = 0;
        2:       cs = $urandom_range(0, 959);
        3:       cs = 959;
        default: cs = 1023;
      endcase
      case ($urandom_range(0, 4))
        0, 1:    cw = 960;
        2:       cw = $urandom_range(0, 1023);
        3:       cw = 0;
        default: cw = 1023;
      endcase
      if (ph == 0) begin
        cs = 0;
        cw = 960;
      end
      load_config(cs, cw, $urandom_range(0, 15), $urandom_range(0, 15));
      sent = 0;
      while (sent < 200) begin
        // some bands run with no idling on one or both sides
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 19))
          0: begin
            if ($urandom_range(0, 3) == 0)
              send_req(rect_load($urandom_range(0, 7), $urandom_range(0, 1023),
                                 $urandom_range(0, 1023), $urandom_range(0, 1023),
                                 $urandom_range(0, 1023)));
            else
              send_req(rect_load($urandom_range(0, 7), $urandom_range(0, 959),
                                 $urandom_range(0, 539), $urandom_range(0, 240),
                                 $urandom_range(0, 135)));
            sent++;
          end
          1, 2: begin
            send_req(random_req());
            sent++;
          end
          default: begin
            len  = $urandom_range(1, 32);
            row  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                               : $urandom_range(0, 539);
            bcol = $urandom_range(0, 479);
            for (int j = 0; j < len; j++) begin
              send_req(pixel_pair(j == 0, j == len - 1, row, bcol,
                                  $urandom_range(0, 255), $urandom_range(0, 255)));
              bcol++;
              if (bcol == PANEL_W / 2) begin
                bcol = 0;
                row++;
              end
            end
            sent += len;
          end
        endcase
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // every pixel in span and ink both before and now, so both counts climb by
  // two per pair over one long band with no restart
  task automatic test_long_band();
    int unsigned n_pairs;
    n_pairs = 100;
    load_config(0, 960, 15, 0);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (int unsigned j = 0; j < n_pairs; j++)
      send_req(pixel_pair(j == 0, j == n_pairs - 1, $urandom_range(0, 539),
                          $urandom_range(0, 479), $urandom_range(0, 255),
                          $urandom_range(0, 255)));
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // result receiver: after each transfer it stalls a random number of cycles,
  // or as long as a pending hold-off request asks
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready)
        stall_left = rx_idle_on ? $urandom_range(0, 8) : 0;
      if (rx_hold_req != 0) begin
        stall_left = rx_hold_req;
        rx_hold_req = 0;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_masks.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual mask %0h ink %0h addr %0h",
                 $time, out_ch.erase_mask, out_ch.ink_bits, out_ch.ink_byte_addr);
        fails++;
      end else begin
        want = pending_masks.pop_front();
        check_field("erase_mask", 32'(want.erase_mask), 32'(out_ch.erase_mask));
        check_field("ink_bits", 32'(want.ink_bits), 32'(out_ch.ink_bits));
        check_field("ink_byte_addr", 32'(want.ink_byte_addr), 32'(out_ch.ink_byte_addr));
        check_field("ink_bit_offset", 32'(want.ink_bit_offset),
                    32'(out_ch.ink_bit_offset));
        check_field("any_erase", 32'(want.any_erase), 32'(out_ch.any_erase));
        check_field("erase_count", 32'(want.erase_count), 32'(out_ch.erase_count));
        check_field("ink_count", 32'(want.ink_count), 32'(out_ch.ink_count));
        check_field("band_end", 32'(want.band_end), 32'(out_ch.band_end));
      end
    end
  end

  // hang detection: too long with no transfer on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending_masks.size());
      $display("tb_epaper_diff_erase_ink_mask failed");
      $finish;
    end
  end

  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_COL_START;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.req_type    <= REQ_PIXEL;
    in_ch.band_first  <= 1'b0;
    in_ch.band_last   <= 1'b0;
    in_ch.pixel_row   <= '0;
    in_ch.byte_col    <= '0;
    in_ch.cur_byte    <= '0;
    in_ch.prev_byte   <= '0;
    in_ch.rect_slot   <= '0;
    in_ch.rect_left   <= '0;
    in_ch.rect_top    <= '0;
    in_ch.rect_width  <= '0;
    in_ch.rect_height <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_keep_rects();
    test_span_edges();
    test_back_pressure();
    test_drain_pause();
    test_random_bands();
    test_long_band();

    drain_results();
    if (pending_masks.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_masks.size());
      fails++;
    end
    if (fails == 0)
      $display("tb_epaper_diff_erase_ink_mask passed");
    else
      $display("tb_epaper_diff_erase_ink_mask failed");
    $finish;
  end

endmodule
